// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, codes and the command and status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS_DEFAULT       = 256;
    localparam int KEY_BYTES_DEFAULT   = 8;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int OCC_BITS    = 9;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [KEY_BITS-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash_step;
        logic probe_start;
        logic probe_next;
        logic finish;
    } lpht_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic op_valid;
        logic hash_done;
        logic probe_stop;
    } lpht_sts_t;

endpackage

// ===== rtl/core/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key/value table with linear probing, tombstones and an
// FNV-1a 64 hash of a zero-terminated key of up to eight bytes.
// ----------------------------------------------------------------------------
// Each input transfer carries an operation (lookup, insert or remove), a key
// and a value; each produces exactly one result transfer with a status, the
// value found or removed, and the number of occupied slots afterwards.
// Both channels use valid and ready. After an input transfer the block hashes
// one key byte per cycle for the L bytes before the terminating zero, starts
// the probe, then reads one slot per cycle from the slot memories for the P
// slots visited, and finally writes the table and the result register; an
// unknown operation skips the hashing and the probe. The result becomes
// valid in the same cycle in which the next input can be taken. The result
// register lets a new item be taken while a result still waits; if the
// receiver stalls, the following item waits in its final state until the
// register is free. After reset the slot state memory is cleared one slot
// per cycle, and s_ready stays low until the clearing pass ends.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
    parameter int SLOTS       = lpht_pkg::SLOTS_DEFAULT,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEFAULT,
    parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lpht_pkg::OP_BITS-1:0]     s_operation,
    input  logic [lpht_pkg::KEY_BITS-1:0]    s_key,
    input  logic [lpht_pkg::VALUE_BITS-1:0]  s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lpht_pkg::STATUS_BITS-1:0] m_status,
    output logic [lpht_pkg::VALUE_BITS-1:0]  m_value_out,
    output logic [lpht_pkg::OCC_BITS-1:0]    m_occupied
);
    import lpht_pkg::*;

    lpht_cmd_t cmd;
    lpht_sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpht_dpath #(
        .SLOTS       (SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_status    (m_status),
        .m_value_out (m_value_out),
        .m_occupied  (m_occupied)
    );

    a_full_means_all_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |-> m_occupied == OCC_BITS'(SLOTS))
        else $error("Table full reported while some slot is not occupied.");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second item was offered a transfer while one is in work.");

    a_miss_has_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_DONE) |-> m_value_out == '0)
        else $error("A failed operation returned a nonzero value.");

endmodule

// ===== rtl/core/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences the clearing pass, hashing, probing and the final update, and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module lpht_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lpht_pkg::lpht_sts_t sts,
    output lpht_pkg::lpht_cmd_t cmd
);
    import lpht_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.op_valid ? S_HASH : S_FINISH;
                end
            end
            S_HASH: begin
                if (sts.hash_done) begin
                    cmd.probe_start = 1'b1;
                    state_next      = S_CHECK;
                end else begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_CHECK: begin
                if (sts.probe_stop) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.probe_next = 1'b1;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/lpht_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Key normalization, the FNV-1a hash unit, the slot memories, the probe
// address and tombstone tracking, and the result register.
// ----------------------------------------------------------------------------
module lpht_dpath #(
    parameter int SLOTS       = lpht_pkg::SLOTS_DEFAULT,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEFAULT,
    parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lpht_pkg::lpht_cmd_t                 cmd,
    output lpht_pkg::lpht_sts_t                 sts,
    input  logic [lpht_pkg::OP_BITS-1:0]        s_operation,
    input  logic [lpht_pkg::KEY_BITS-1:0]       s_key,
    input  logic [lpht_pkg::VALUE_BITS-1:0]     s_value,
    output logic [lpht_pkg::STATUS_BITS-1:0]    m_status,
    output logic [lpht_pkg::VALUE_BITS-1:0]     m_value_out,
    output logic [lpht_pkg::OCC_BITS-1:0]       m_occupied
);
    import lpht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int VW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
    localparam int BW = $clog2(KEY_BYTES + 1);

    logic [1:0]          state_mem [SLOTS];
    logic [KEY_BITS-1:0] key_mem   [SLOTS];
    logic [VW-1:0]       value_mem [SLOTS];

    logic [1:0]             state_rd_reg;
    logic [KEY_BITS-1:0]    key_rd_reg;
    logic [VW-1:0]          value_rd_reg;

    logic [OP_BITS-1:0]     op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VW-1:0]          val_reg;
    logic [KEY_BITS-1:0]    hash_reg;
    logic [BW-1:0]          byte_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          tomb_reg;
    logic                   have_tomb_reg;
    logic [AW-1:0]          probe_cnt_reg;
    logic [AW-1:0]          clr_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [VALUE_BITS-1:0]  vout_reg;
    logic [VALUE_BITS-1:0]  vout_next;
    logic [OCC_BITS-1:0]    occ_reg;

    logic [KEY_BITS-1:0]    norm_key;
    logic [7:0]             cur_byte;
    logic [KEY_BITS-1:0]    hash_x;
    logic [KEY_BITS-1:0]    hash_next;
    logic [AW-1:0]          idx_inc;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic                   cur_empty;
    logic                   cur_tomb;
    logic                   cur_match;
    logic                   tomb_any;
    logic [AW-1:0]          tomb_addr;

    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    logic [1:0]             st_wdata;
    logic                   key_we;
    logic                   val_we;
    logic [AW-1:0]          kv_waddr;

    // The key is cut at the first zero byte or after KEY_BYTES bytes.
    always_comb begin
        logic alive;
        alive    = 1'b1;
        norm_key = '0;
        for (int i = 0; i < KEY_BITS / 8; i++) begin
            if (i >= KEY_BYTES || s_key[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                norm_key[8*i +: 8] = s_key[8*i +: 8];
            end
        end
    end

    assign cur_byte = key_reg[{3'(byte_reg), 3'b000} +: 8];

    // Multiply by the FNV prime 2^40 + 0x1B3 as a sum of shifted terms.
    assign hash_x    = hash_reg ^ {{(KEY_BITS-8){1'b0}}, cur_byte};
    assign hash_next = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
                     + (hash_x << 4) + (hash_x << 1) + hash_x;

    assign idx_inc   = idx_reg + AW'(1);
    assign rd_en     = cmd.probe_start || cmd.probe_next;
    assign rd_addr   = cmd.probe_start ? hash_reg[AW-1:0] : idx_inc;

    assign cur_empty = (state_rd_reg == ST_EMPTY);
    assign cur_tomb  = (state_rd_reg == ST_TOMB);
    assign cur_match = (state_rd_reg == ST_USED) && (key_rd_reg == key_reg);
    assign tomb_any  = have_tomb_reg || cur_tomb;
    assign tomb_addr = have_tomb_reg ? tomb_reg : idx_reg;

    assign sts.clear_last = (clr_reg == {AW{1'b1}});
    assign sts.op_valid   = (s_operation == OP_LOOKUP) || (s_operation == OP_INSERT)
                         || (s_operation == OP_REMOVE);
    assign sts.hash_done  = (byte_reg == BW'(KEY_BYTES)) || (cur_byte == 8'd0);
    assign sts.probe_stop = cur_empty || cur_match || (probe_cnt_reg == {AW{1'b1}});

    always_comb begin
        st_we       = cmd.clear;
        st_waddr    = clr_reg;
        st_wdata    = ST_EMPTY;
        key_we      = 1'b0;
        val_we      = 1'b0;
        kv_waddr    = idx_reg;
        count_next  = count_reg;
        status_next = STATUS_NOTFOUND;
        vout_next   = '0;
        unique case (op_reg) inside
            OP_LOOKUP, OP_REMOVE: begin
                if (cur_match) begin
                    status_next = STATUS_DONE;
                    vout_next   = VALUE_BITS'(value_rd_reg);
                    if (op_reg == OP_REMOVE) begin
                        st_we      = cmd.finish;
                        st_waddr   = idx_reg;
                        st_wdata   = ST_TOMB;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            OP_INSERT: begin
                if (cur_match) begin
                    status_next = STATUS_DONE;
                    val_we      = cmd.finish;
                end else if (tomb_any || cur_empty) begin
                    status_next = STATUS_DONE;
                    kv_waddr    = tomb_any ? tomb_addr : idx_reg;
                    st_we       = cmd.finish;
                    st_waddr    = kv_waddr;
                    st_wdata    = ST_USED;
                    key_we      = cmd.finish;
                    val_we      = cmd.finish;
                    count_next  = count_reg + CW'(1);
                end else begin
                    status_next = STATUS_FULL;
                end
            end
            default: begin
                status_next = STATUS_NOTFOUND;
            end
        endcase
        // The clearing pass owns the state memory whatever the last operation was.
        if (cmd.clear) begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
            st_wdata = ST_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (key_we) begin
            key_mem[kv_waddr] <= key_reg;
        end
        if (val_we) begin
            value_mem[kv_waddr] <= val_reg;
        end
        if (rd_en) begin
            state_rd_reg <= state_mem[rd_addr];
            key_rd_reg   <= key_mem[rd_addr];
            value_rd_reg <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.finish) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            key_reg  <= norm_key;
            val_reg  <= s_value[VW-1:0];
            hash_reg <= FNV_BASIS;
            byte_reg <= '0;
        end
        if (cmd.hash_step) begin
            hash_reg <= hash_next;
            byte_reg <= byte_reg + BW'(1);
        end
        if (cmd.probe_start) begin
            idx_reg       <= hash_reg[AW-1:0];
            probe_cnt_reg <= '0;
            have_tomb_reg <= 1'b0;
        end
        if (cmd.probe_next) begin
            idx_reg       <= idx_inc;
            probe_cnt_reg <= probe_cnt_reg + AW'(1);
            if (cur_tomb && !have_tomb_reg) begin
                have_tomb_reg <= 1'b1;
                tomb_reg      <= idx_reg;
            end
        end
        if (cmd.finish) begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
            occ_reg    <= OCC_BITS'(count_next);
        end
    end

    assign m_status    = status_reg;
    assign m_value_out = vout_reg;
    assign m_occupied  = occ_reg;

endmodule
